>>> rtl/crpr_pkg.sv
// ----------------------------------------------------------------------------
// crpr_pkg
// Shared types and constants of the code-rain pixel renderer.
// ----------------------------------------------------------------------------
package crpr_pkg;

  localparam int DIV_WIDTH      = 8;
  localparam int DIV_BITS_STAGE = 2;
  localparam int DIV_STAGES     = DIV_WIDTH / DIV_BITS_STAGE;

  typedef enum logic [1:0] {
    ACT_KEEP  = 2'd0,
    ACT_ON    = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_DIM   = 2'd3
  } crpr_action_t;

  typedef enum logic [2:0] {
    REG_SEED        = 3'd0,
    REG_HASH_FACTOR = 3'd1,
    REG_MAX_DELAY   = 3'd2,
    REG_TRAIL_BRIGHT = 3'd3,
    REG_TRAIL_STEPS = 3'd4,
    REG_REVEAL_STEP = 3'd5,
    REG_FRAME_TOTAL = 3'd6
  } crpr_reg_t;

  typedef struct packed {
    logic [6:0]   rem;
    logic [7:0]   num;
    logic [7:0]   quo;
    logic [6:0]   den;
    crpr_action_t action;
    logic         done;
  } crpr_div_t;

endpackage

>>> rtl/crpr_in_if.sv
// ----------------------------------------------------------------------------
// crpr_in_if
// Pixel request channel: column, row, frame number and word flag.
// ----------------------------------------------------------------------------
interface crpr_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] column;
  logic [3:0] row;
  logic [7:0] frame_index;
  logic       word_pixel;

  modport source (output valid, output column, output row, output frame_index,
                  output word_pixel, input ready);
  modport sink (input valid, input column, input row, input frame_index,
                input word_pixel, output ready);
endinterface

>>> rtl/crpr_out_if.sv
// ----------------------------------------------------------------------------
// crpr_out_if
// Pixel result channel: action, dim level and animation done flag.
// ----------------------------------------------------------------------------
interface crpr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] brightness;
  logic       done_res;

  modport source (output valid, output action, output brightness,
                  output done_res, input ready);
  modport sink (input valid, input action, input brightness,
                input done_res, output ready);
endinterface

>>> rtl/crpr_div_stage.sv
// ----------------------------------------------------------------------------
// crpr_div_stage
// One registered stage of the restoring divider: two quotient bits per beat.
// ----------------------------------------------------------------------------
module crpr_div_stage
  import crpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  crpr_div_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output crpr_div_t dn_data
);

  logic      valid_r;
  crpr_div_t data_r;
  crpr_div_t data_nxt;

  function automatic crpr_div_t div_bit(input crpr_div_t d);
    crpr_div_t  o;
    logic [7:0] shifted;
    logic [8:0] trial;
    o       = d;
    shifted = {d.rem, d.num[7]};
    trial   = {1'b0, shifted} - {2'b00, d.den};
    o.num   = {d.num[6:0], 1'b0};
    if (!trial[8]) begin
      o.rem = trial[6:0];
      o.quo = {d.quo[6:0], 1'b1};
    end else begin
      o.rem = shifted[6:0];
      o.quo = {d.quo[6:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    data_nxt = up_data;
    for (int i = 0; i < DIV_BITS_STAGE; i++) begin
      data_nxt = div_bit(data_nxt);
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/code_rain_pixel_renderer.sv
// ----------------------------------------------------------------------------
// code_rain_pixel_renderer
// Decides per pixel of a code-rain frame: leave, full on, clear or dim.
// ----------------------------------------------------------------------------
// One pixel beat is accepted every cycle unless the result side stalls. Five
// register stages hash the column to its start frame and decode the pixel
// (two 8-bit product stages, a scaling product, the drop head, the trail
// decode); four more run a restoring divider, two quotient bits per stage,
// for the dim level. Each stage holds its own valid bit and fills a bubble
// while the result side stalls. The user must write configuration through
// cfg_we, cfg_index, cfg_data only while no pixel is in flight; not enforced.
module code_rain_pixel_renderer
  import crpr_pkg::*;
#(
  parameter int NUM_ROWS    = 10,
  parameter int NUM_COLUMNS = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  crpr_in_if.sink    in_ch,
  crpr_out_if.source out_ch
);

  localparam int CmpW = 7;

  typedef struct packed {
    logic [7:0] hash;
    logic [3:0] row;
    logic [7:0] frame;
    logic       word;
    logic       done;
    logic       on;
  } crpr_hash_t;

  typedef struct packed {
    logic [7:0] head;
    logic       started;
    logic [3:0] row;
    logic       word;
    logic       done;
    logic       on;
  } crpr_head_t;

  logic [7:0] seed_r;
  logic [7:0] hash_factor_r;
  logic [7:0] max_delay_r;
  logic [7:0] trail_bright_r;
  logic [6:0] trail_steps_r;
  logic [6:0] reveal_step_r;
  logic [7:0] frame_total_r;

  logic [4:0] v_r;
  logic [5:0] rdy;

  crpr_hash_t s1_r, s1_nxt;
  crpr_hash_t s2_r, s2_nxt;
  crpr_hash_t s3_r, s3_nxt;
  crpr_head_t s4_r, s4_nxt;
  crpr_div_t  s5_r, s5_nxt;

  crpr_div_t  dv   [DIV_STAGES+1];
  logic       dvv  [DIV_STAGES+1];
  logic       dvr  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r         <= 8'd0;
      hash_factor_r  <= 8'd167;
      max_delay_r    <= 8'd16;
      trail_bright_r <= 8'd255;
      trail_steps_r  <= 7'd4;
      reveal_step_r  <= 7'd2;
      frame_total_r  <= 8'd64;
    end else if (cfg_we) begin
      case (crpr_reg_t'(cfg_index))
        REG_SEED:         seed_r         <= cfg_data;
        REG_HASH_FACTOR:  hash_factor_r  <= cfg_data;
        REG_MAX_DELAY:    max_delay_r    <= cfg_data;
        REG_TRAIL_BRIGHT: trail_bright_r <= cfg_data;
        REG_TRAIL_STEPS:  trail_steps_r  <= cfg_data[6:0];
        REG_REVEAL_STEP:  reveal_step_r  <= cfg_data[6:0];
        REG_FRAME_TOTAL:  frame_total_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage ready chain
  always_comb begin
    rdy[5] = dvr[0];
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end
  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_ch.valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
    end
  end

  // stage 1: first hash product
  logic [7:0]  col_seed;
  logic [15:0] prod1;
  always_comb begin
    col_seed     = 8'({4'd0, in_ch.column} + seed_r);
    prod1        = col_seed * hash_factor_r;
    s1_nxt.hash  = prod1[7:0];
    s1_nxt.row   = in_ch.row;
    s1_nxt.frame = in_ch.frame_index;
    s1_nxt.word  = in_ch.word_pixel;
    s1_nxt.done  = in_ch.frame_index >= frame_total_r;
    s1_nxt.on    = (CmpW'(in_ch.column) < CmpW'(NUM_COLUMNS))
                && (CmpW'(in_ch.row) < CmpW'(NUM_ROWS));
  end

  // stage 2: fold and second product
  logic [7:0]  fold;
  logic [15:0] prod2;
  always_comb begin
    fold        = s1_r.hash ^ {4'd0, s1_r.hash[7:4]};
    prod2       = fold * hash_factor_r;
    s2_nxt      = s1_r;
    s2_nxt.hash = prod2[7:0];
  end

  // stage 3: scale to start frame
  logic [15:0] prod3;
  always_comb begin
    prod3       = s2_r.hash * max_delay_r;
    s3_nxt      = s2_r;
    s3_nxt.hash = prod3[15:8];
  end

  // stage 4: drop head
  always_comb begin
    s4_nxt.started = s3_r.frame >= s3_r.hash;
    s4_nxt.head    = s3_r.frame - s3_r.hash;
    s4_nxt.row     = s3_r.row;
    s4_nxt.word    = s3_r.word;
    s4_nxt.done    = s3_r.done;
    s4_nxt.on      = s3_r.on;
  end

  // stage 5: trail decode
  logic [7:0] row_w;
  logic [7:0] gap;
  logic [8:0] gap_inc;
  logic [7:0] fade;
  always_comb begin
    row_w    = {4'd0, s4_r.row};
    gap      = s4_r.head - row_w;
    gap_inc  = {1'b0, gap} + 9'd1;
    fade     = gap_inc[8:1];
    s5_nxt.rem    = '0;
    s5_nxt.num    = trail_bright_r;
    s5_nxt.quo    = '0;
    s5_nxt.den    = 7'd1;
    s5_nxt.done   = s4_r.done;
    s5_nxt.action = ACT_KEEP;
    if (!s4_r.done && s4_r.on && s4_r.started) begin
      if (row_w == s4_r.head) begin
        s5_nxt.action = ACT_ON;
      end else if (row_w < s4_r.head) begin
        if (s4_r.word && fade > {1'b0, reveal_step_r}) begin
          s5_nxt.action = ACT_ON;
        end else if (fade > {1'b0, trail_steps_r}) begin
          s5_nxt.action = ACT_CLEAR;
        end else begin
          s5_nxt.action = ACT_DIM;
          s5_nxt.den    = fade[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_ch.valid) s1_r <= s1_nxt;
    if (rdy[1] && v_r[0])      s2_r <= s2_nxt;
    if (rdy[2] && v_r[1])      s3_r <= s3_nxt;
    if (rdy[3] && v_r[2])      s4_r <= s4_nxt;
    if (rdy[4] && v_r[3])      s5_r <= s5_nxt;
  end

  // divider pipeline
  assign dv[0]  = s5_r;
  assign dvv[0] = v_r[4];
  assign dvr[DIV_STAGES] = out_ch.ready;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    crpr_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dvv[g]),
      .up_ready (dvr[g]),
      .up_data  (dv[g]),
      .dn_valid (dvv[g+1]),
      .dn_ready (dvr[g+1]),
      .dn_data  (dv[g+1])
    );
  end

  assign out_ch.valid      = dvv[DIV_STAGES];
  assign out_ch.action     = dv[DIV_STAGES].action;
  assign out_ch.brightness = (dv[DIV_STAGES].action == ACT_DIM) ? dv[DIV_STAGES].quo : 8'd0;
  assign out_ch.done_res   = dv[DIV_STAGES].done;

endmodule

>>> dv/crpr_pixel_checker.sv
// ----------------------------------------------------------------------------
// crpr_pixel_checker
// Watches the pixel and result channels of the code-rain pixel renderer,
// keeps a shadow copy of its registers, predicts the action, dim level and
// done flag of every accepted pixel beat, and compares each result beat with
// the oldest pending prediction. Hands the failure count and the number of
// pending predictions to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crpr_pixel_checker
  import crpr_pkg::*;
#(
  parameter int NUM_ROWS    = 10,
  parameter int NUM_COLUMNS = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  crpr_in_if          in_mon,
  crpr_out_if         out_mon,
  output int unsigned err_count,
  output int unsigned pend_count
);

  typedef struct packed {
    crpr_action_t action;
    logic [7:0]   brightness;
    logic         done_res;
  } pixel_result_t;

  pixel_result_t pending_pixels_q[$];

  logic [7:0] seed_r;
  logic [7:0] hash_factor_r;
  logic [7:0] max_delay_r;
  logic [7:0] trail_bright_r;
  logic [6:0] trail_steps_r;
  logic [6:0] reveal_step_r;
  logic [7:0] frame_total_r;
  int unsigned errs;

  function automatic logic [7:0] column_start_frame(logic [3:0] col);
    logic [15:0] prod;
    logic [7:0]  h;
    prod = (16'(seed_r) + 16'(col)) * 16'(hash_factor_r);
    h    = prod[7:0];
    h    = h ^ (h >> 4);
    prod = 16'(h) * 16'(hash_factor_r);
    h    = prod[7:0];
    prod = 16'(h) * 16'(max_delay_r);
    return prod[15:8];
  endfunction

  function automatic pixel_result_t render_pixel(logic [3:0] col, logic [3:0] row,
                                                 logic [7:0] frame, logic word);
    pixel_result_t r;
    logic [7:0]    start;
    int            head;
    int            fade;
    r = '{action: ACT_KEEP, brightness: 8'd0, done_res: 1'b0};
    if (frame >= frame_total_r) begin
      r.done_res = 1'b1;
    end else if (col < NUM_COLUMNS && row < NUM_ROWS) begin
      start = column_start_frame(col);
      if (frame >= start) begin
        head = int'(frame) - int'(start);
        if (int'(row) == head) begin
          r.action = ACT_ON;
        end else if (int'(row) < head) begin
          fade = (head - int'(row) + 1) / 2;
          if (word && fade > int'(reveal_step_r)) begin
            r.action = ACT_ON;
          end else if (fade > int'(trail_steps_r)) begin
            r.action = ACT_CLEAR;
          end else begin
            r.action     = ACT_DIM;
            r.brightness = 8'(int'(trail_bright_r) / fade);
          end
        end
      end
    end
    return r;
  endfunction

  task automatic flag_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
    errs++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    pixel_result_t exp_r;
    pixel_result_t got_r;
    if (!rst_n) begin
      seed_r         = 8'd0;
      hash_factor_r  = 8'd167;
      max_delay_r    = 8'd16;
      trail_bright_r = 8'd255;
      trail_steps_r  = 7'd4;
      reveal_step_r  = 7'd2;
      frame_total_r  = 8'd64;
      errs           = 0;
      pending_pixels_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEED:         seed_r         = cfg_data;
          REG_HASH_FACTOR:  hash_factor_r  = cfg_data;
          REG_MAX_DELAY:    max_delay_r    = cfg_data;
          REG_TRAIL_BRIGHT: trail_bright_r = cfg_data;
          REG_TRAIL_STEPS:  trail_steps_r  = cfg_data[6:0];
          REG_REVEAL_STEP:  reveal_step_r  = cfg_data[6:0];
          REG_FRAME_TOTAL:  frame_total_r  = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        pending_pixels_q.push_back(render_pixel(in_mon.column, in_mon.row,
                                                in_mon.frame_index, in_mon.word_pixel));
      if (out_mon.valid && out_mon.ready) begin
        got_r = '{action: crpr_action_t'(out_mon.action), brightness: out_mon.brightness,
                  done_res: out_mon.done_res};
        if (pending_pixels_q.size() == 0) begin
          errs++;
          $display("%0t: result beat with no pending pixel, expected none, got %0d/%0d/%0d",
                   $time, got_r.action, got_r.brightness, got_r.done_res);
        end else begin
          exp_r = pending_pixels_q.pop_front();
          if (got_r.action !== exp_r.action)
            flag_field("action", 8'(exp_r.action), 8'(out_mon.action));
          if (got_r.brightness !== exp_r.brightness)
            flag_field("brightness", exp_r.brightness, out_mon.brightness);
          if (got_r.done_res !== exp_r.done_res)
            flag_field("done_res", 8'(exp_r.done_res), 8'(out_mon.done_res));
        end
      end
    end
    err_count  <= errs;
    pend_count <= pending_pixels_q.size();
  end

endmodule

>>> dv/code_rain_pixel_renderer_tb.sv
// ----------------------------------------------------------------------------
// code_rain_pixel_renderer_tb
// Drives pixel beats into the code-rain pixel renderer: a directed set of
// edge cases at reset settings, then random pixels over several register
// settings, extremes included, with random idling on both channels in most
// phases, one long result-side hold-off and full drains. A separate checker
// predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module code_rain_pixel_renderer_tb;
  import crpr_pkg::*;

  localparam int          NUM_ROWS     = 10;
  localparam int          NUM_COLUMNS  = 11;
  localparam int          LATENCY      = 9;
  localparam int          NUM_PHASES   = 9;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 150000;
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  int unsigned err_count;
  int unsigned pend_count;
  int unsigned cycle_count = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_reqs = 0;
  logic [7:0]  cur_frame_total;

  crpr_in_if  in_ch ();
  crpr_out_if out_ch ();

  code_rain_pixel_renderer #(
    .NUM_ROWS    (NUM_ROWS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  crpr_pixel_checker #(
    .NUM_ROWS    (NUM_ROWS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .err_count  (err_count),
    .pend_count (pend_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("code_rain_pixel_renderer test failed");
      $finish;
    end
  end

  // result side: random idling plus long hold-offs on request
  initial begin
    int stalls_served;
    int hold_left;
    stalls_served = 0;
    hold_left     = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (stall_reqs != stalls_served) begin
          stalls_served++;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_FRAME_TOTAL)
      cur_frame_total = val;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [3:0] col, input logic [3:0] row,
                            input logic [7:0] frame, input logic word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.column      <= col;
    in_ch.row         <= row;
    in_ch.frame_index <= frame;
    in_ch.word_pixel  <= word;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
  endtask

  task automatic send_random_pixel();
    logic [3:0] col;
    logic [3:0] row;
    logic [7:0] frame;
    int         frame_max;
    frame_max = (cur_frame_total == 8'd0) ? 255 : int'(cur_frame_total) - 1;
    if ($urandom_range(99) < 85) begin
      col   = 4'($urandom_range(NUM_COLUMNS - 1));
      row   = 4'($urandom_range(NUM_ROWS - 1));
      frame = 8'($urandom_range(frame_max));
    end else begin
      col   = 4'($urandom_range(15));
      row   = 4'($urandom_range(15));
      frame = 8'($urandom_range(255));
    end
    send_pixel(col, row, frame, 1'($urandom_range(1)));
  endtask

  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend_count != 0)
      @(posedge clk);
  endtask

  task automatic load_setting(input int ph);
    case (ph)
      1: begin
        write_reg(REG_SEED, 8'd255);
        write_reg(REG_HASH_FACTOR, 8'd255);
        write_reg(REG_MAX_DELAY, 8'd255);
        write_reg(REG_TRAIL_BRIGHT, 8'd0);
        write_reg(REG_TRAIL_STEPS, 8'hFF);
        write_reg(REG_REVEAL_STEP, 8'hFF);
        write_reg(REG_FRAME_TOTAL, 8'd255);
      end
      2: begin
        write_reg(REG_SEED, 8'd0);
        write_reg(REG_HASH_FACTOR, 8'd0);
        write_reg(REG_MAX_DELAY, 8'd0);
        write_reg(REG_TRAIL_BRIGHT, 8'd255);
        write_reg(REG_TRAIL_STEPS, 8'd1);
        write_reg(REG_REVEAL_STEP, 8'd0);
        write_reg(REG_FRAME_TOTAL, 8'd200);
      end
      3: begin
        write_reg(REG_HASH_FACTOR, 8'd167);
        write_reg(REG_MAX_DELAY, 8'd16);
        write_reg(REG_FRAME_TOTAL, 8'd1);
      end
      4: begin
        write_reg(REG_FRAME_TOTAL, 8'd0);
        write_reg(REG_UNMAPPED, 8'h5A);
      end
      default: begin
        write_reg(REG_SEED, 8'($urandom_range(255)));
        write_reg(REG_HASH_FACTOR, 8'($urandom_range(255)) | 8'd1);
        write_reg(REG_MAX_DELAY, 8'($urandom_range(40)));
        write_reg(REG_TRAIL_BRIGHT, 8'($urandom_range(255)));
        write_reg(REG_TRAIL_STEPS, (ph == 5) ? 8'd0 : 8'($urandom_range(1, 10)));
        write_reg(REG_REVEAL_STEP, 8'($urandom_range(6)));
        write_reg(REG_FRAME_TOTAL, 8'($urandom_range(20, 100)));
      end
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int ph;
    int n;
    int phase_items;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.column      = '0;
    in_ch.row         = '0;
    in_ch.frame_index = '0;
    in_ch.word_pixel  = 1'b0;
    cur_frame_total   = 8'd64;
    send_idle_pct     = 22;
    recv_idle_pct     = 71;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // head, trail dim levels, reveal threshold, clear, below head
    send_pixel(4'd0, 4'd0, 8'd0, 1'b0);
    send_pixel(4'd0, 4'd0, 8'd1, 1'b0);
    send_pixel(4'd0, 4'd0, 8'd2, 1'b1);
    send_pixel(4'd0, 4'd0, 8'd3, 1'b0);
    send_pixel(4'd0, 4'd0, 8'd4, 1'b1);
    send_pixel(4'd0, 4'd0, 8'd5, 1'b1);
    send_pixel(4'd0, 4'd0, 8'd5, 1'b0);
    send_pixel(4'd0, 4'd0, 8'd9, 1'b0);
    send_pixel(4'd0, 4'd0, 8'd10, 1'b1);
    send_pixel(4'd0, 4'd5, 8'd2, 1'b0);
    send_pixel(4'd0, 4'd9, 8'd9, 1'b0);
    // column not started, then its head, then a revealed word pixel
    send_pixel(4'd1, 4'd0, 8'd5, 1'b1);
    send_pixel(4'd1, 4'd0, 8'd13, 1'b0);
    send_pixel(4'd10, 4'd9, 8'd40, 1'b1);
    // off the display
    send_pixel(4'd11, 4'd0, 8'd20, 1'b1);
    send_pixel(4'd15, 4'd3, 8'd20, 1'b0);
    send_pixel(4'd2, 4'd10, 8'd20, 1'b1);
    send_pixel(4'd2, 4'd15, 8'd20, 1'b0);
    // last frame and finished animation
    send_pixel(4'd0, 4'd0, 8'd63, 1'b0);
    send_pixel(4'd0, 4'd0, 8'd64, 1'b1);
    send_pixel(4'd15, 4'd15, 8'd255, 1'b1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_pixels();
        repeat (LATENCY + 3) @(posedge clk);
        load_setting(ph);
      end
      if (ph < 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 71;
      end else if (ph < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_items = (ph == 3 || ph == 4) ? 40 : 170;
      for (n = 0; n < phase_items; n++) begin
        if (ph == 1 && n == 40)
          stall_reqs++;
        if (ph == 5 && n == 80)
          drain_pixels();
        send_random_pixel();
      end
    end

    drain_pixels();
    repeat (2 * LATENCY) @(posedge clk);
    if (err_count == 0 && pend_count == 0) begin
      $display("code_rain_pixel_renderer test passed");
    end else begin
      $display("code_rain_pixel_renderer test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/crpr_pkg.sv
rtl/crpr_in_if.sv
rtl/crpr_out_if.sv
rtl/crpr_div_stage.sv
rtl/code_rain_pixel_renderer.sv
dv/crpr_pixel_checker.sv
dv/code_rain_pixel_renderer_tb.sv
